### rtl/slt_pkg.sv
// Shared constants and types for the sorted list table.
`default_nettype none
package slt_pkg;
	localparam int Depth = 16;
	localparam int PosW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam int DataW = 32;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_REMOVE_ONE = 3'd1;
	localparam logic [2:0] ACT_REMOVE_ALL = 3'd2;
	localparam logic [2:0] ACT_FIND_FIRST = 3'd3;
	localparam logic [2:0] ACT_FIND_ALL = 3'd4;
	localparam logic [2:0] ACT_READ_AT = 3'd5;

	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_EMPTY = 3'd1;
	localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
	localparam logic [2:0] STAT_FULL = 3'd3;
	localparam logic [2:0] STAT_NO_POS = 3'd4;

	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_SHIFT = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic signed [DataW-1:0] value;
	} cell_ctl_t;
endpackage
`default_nettype wire

### rtl/slt_cell.sv
// One compare-and-shift cell of the sorted list chain.
`default_nettype none
module slt_cell (
	input wire logic clk,
	input wire slt_pkg::cell_ctl_t ctl,
	input wire logic occupied,
	input wire logic at_end,
	input wire logic left_ins,
	input wire logic signed [slt_pkg::DataW-1:0] left_value,
	input wire logic signed [slt_pkg::DataW-1:0] right_value,
	output logic signed [slt_pkg::DataW-1:0] entry_value,
	output logic ins,
	output logic eq,
	output logic lt
);
	import slt_pkg::*;

	logic signed [DataW-1:0] entry_q;
	logic lt_raw;
	logic eq_raw;

	assign lt_raw = entry_q < ctl.value;
	assign eq_raw = entry_q == ctl.value;
	assign lt = occupied && lt_raw;
	assign eq = occupied && eq_raw;
	assign ins = (occupied && !lt_raw && !eq_raw) || at_end;
	assign entry_value = entry_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_INSERT: begin
				if (ins)
					entry_q <= left_ins ? left_value : ctl.value;
			end
			OP_SHIFT: begin
				if (occupied && !lt_raw)
					entry_q <= right_value;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

### rtl/sorted_list_table.sv
// Sorted list table top level: command sequencer, cell chain and result register.
// Accepted word and its result are both registered; out_stall can hold the exec state.
// A new word is not taken until the last is done; in_stall is high while a word is in work.
// Remove-all drops matches one by one; find-all gives one result a cycle when not stalled.
// Reset clears the entry count and the sequencer; entry storage is not cleared.
`default_nettype none
module sorted_list_table (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [2:0] action,
	input wire logic signed [31:0] value,
	input wire logic [3:0] position,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] status,
	output logic signed [31:0] found_value,
	output logic [3:0] found_position,
	output logic [4:0] held_count,
	output logic [4:0] removed_count,
	output logic last
);
	import slt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_RALL = 2'd2;
	localparam logic [1:0] S_FALL = 2'd3;

	logic [1:0] state_q;
	logic [CntW-1:0] count_q;
	logic [2:0] action_q;
	logic signed [DataW-1:0] value_q;
	logic [PosW-1:0] position_q;
	logic [CntW-1:0] removed_q;
	logic [PosW-1:0] cur_q;
	logic [CntW-1:0] rem_q;

	logic out_valid_q;
	logic [2:0] status_q;
	logic signed [DataW-1:0] found_value_q;
	logic [PosW-1:0] found_position_q;
	logic [CntW-1:0] held_count_q;
	logic [CntW-1:0] removed_count_q;
	logic last_q;

	cell_ctl_t ctl;
	logic signed [DataW-1:0] cell_val [Depth];
	logic signed [DataW-1:0] left_val [Depth];
	logic signed [DataW-1:0] right_val [Depth];
	logic [Depth-1:0] occ_v;
	logic [Depth-1:0] end_v;
	logic [Depth-1:0] ins_v;
	logic [Depth-1:0] left_ins_v;
	logic [Depth-1:0] eq_v;
	logic [Depth-1:0] lt_v;

	logic out_free;
	logic accept;
	logic [CntW-1:0] match_cnt;
	logic [PosW-1:0] first_pos;
	logic emit;
	logic [2:0] e_status;
	logic signed [DataW-1:0] e_value;
	logic [PosW-1:0] e_pos;
	logic [CntW-1:0] e_held;
	logic [CntW-1:0] e_removed;
	logic e_last;
	logic [1:0] state_d;
	logic [CntW-1:0] count_d;

	assign in_stall = state_q != S_IDLE;
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign match_cnt = CntW'($countones(eq_v));
	assign first_pos = PosW'($countones(lt_v));

	always_comb begin
		for (int j = 0; j < Depth; j++) begin
			occ_v[j] = CntW'(j) < count_q;
			end_v[j] = CntW'(j) == count_q;
			left_ins_v[j] = (j == 0) ? 1'b0 : ins_v[(j == 0) ? 0 : j - 1];
			left_val[j] = (j == 0) ? '0 : cell_val[(j == 0) ? 0 : j - 1];
			right_val[j] = (j == Depth - 1) ? '0 : cell_val[(j == Depth - 1) ? j : j + 1];
		end
	end

	for (genvar g = 0; g < Depth; g++) begin : g_cell
		slt_cell u_cell (
			.clk(clk),
			.ctl(ctl),
			.occupied(occ_v[g]),
			.at_end(end_v[g]),
			.left_ins(left_ins_v[g]),
			.left_value(left_val[g]),
			.right_value(right_val[g]),
			.entry_value(cell_val[g]),
			.ins(ins_v[g]),
			.eq(eq_v[g]),
			.lt(lt_v[g])
		);
	end

	always_comb begin
		ctl.op = OP_HOLD;
		ctl.value = value_q;
		state_d = state_q;
		count_d = count_q;
		emit = 1'b0;
		e_status = STAT_OK;
		e_value = '0;
		e_pos = '0;
		e_held = count_q;
		e_removed = '0;
		e_last = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (action_q > ACT_READ_AT) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					state_d = S_IDLE;
					emit = 1'b1;
					priority if (action_q == ACT_INSERT) begin
						if (count_q == CntW'(Depth)) begin
							e_status = STAT_FULL;
						end else begin
							ctl.op = OP_INSERT;
							count_d = count_q + 1'b1;
							e_held = count_d;
						end
					end else if (count_q == '0) begin
						e_status = STAT_EMPTY;
					end else if (action_q == ACT_READ_AT) begin
						if ({1'b0, position_q} >= count_q)
							e_status = STAT_NO_POS;
						else
							e_value = cell_val[position_q];
					end else if (match_cnt == '0) begin
						e_status = STAT_NOT_FOUND;
					end else if (action_q == ACT_REMOVE_ONE) begin
						ctl.op = OP_SHIFT;
						count_d = count_q - 1'b1;
						e_held = count_d;
						e_removed = CntW'(1);
					end else if (action_q == ACT_REMOVE_ALL) begin
						emit = 1'b0;
						state_d = S_RALL;
					end else if (action_q == ACT_FIND_FIRST) begin
						e_pos = first_pos;
					end else begin
						emit = 1'b0;
						state_d = S_FALL;
					end
				end
			end
			S_RALL: begin
				if (match_cnt != '0) begin
					ctl.op = OP_SHIFT;
					count_d = count_q - 1'b1;
				end else if (out_free) begin
					emit = 1'b1;
					e_removed = removed_q;
					state_d = S_IDLE;
				end
			end
			S_FALL: begin
				if (out_free) begin
					emit = 1'b1;
					e_pos = cur_q;
					e_last = rem_q == CntW'(1);
					if (e_last)
						state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			value_q <= value;
			position_q <= position;
		end
		if (state_q == S_EXEC) begin
			removed_q <= '0;
			cur_q <= first_pos;
			rem_q <= match_cnt;
		end else if (state_q == S_RALL && match_cnt != '0) begin
			removed_q <= removed_q + 1'b1;
		end else if (state_q == S_FALL && emit) begin
			cur_q <= cur_q + 1'b1;
			rem_q <= rem_q - 1'b1;
		end
		if (emit) begin
			status_q <= e_status;
			found_value_q <= e_value;
			found_position_q <= e_pos;
			held_count_q <= e_held;
			removed_count_q <= e_removed;
			last_q <= e_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign found_value = found_value_q;
	assign found_position = found_position_q;
	assign held_count = held_count_q;
	assign removed_count = removed_count_q;
	assign last = last_q;
endmodule
`default_nettype wire

### verif/sorted_list_checker.sv
// Checker for the sorted list table: predicts every result and compares what the block returns.
module sorted_list_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [2:0] action,
	input logic signed [31:0] value,
	input logic [3:0] position,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] status,
	input logic signed [31:0] found_value,
	input logic [3:0] found_position,
	input logic [4:0] held_count,
	input logic [4:0] removed_count,
	input logic last,
	output int fail_count,
	output int expected_left,
	output int results_seen
);
	import slt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] status;
		logic signed [31:0] found_value;
		logic [3:0] found_position;
		logic [4:0] held_count;
		logic [4:0] removed_count;
		logic last;
	} list_result_t;

	list_result_t awaited_results[$];
	logic signed [31:0] list_vals[Depth];
	int held = 0;

	initial begin
		fail_count = 0;
		expected_left = 0;
		results_seen = 0;
	end

	task automatic apply_to_list(input logic [2:0] act, input logic signed [31:0] val,
			input logic [3:0] pos);
		list_result_t r;
		int idx;
		int first;
		int n;
		int j;
		int k;
		r = '0;
		r.last = 1'b1;
		if (act == ACT_INSERT) begin
			if (held >= Depth) begin
				r.status = STAT_FULL;
			end else begin
				idx = 0;
				while (idx < held && list_vals[idx] <= val)
					idx++;
				for (j = held; j > idx; j--)
					list_vals[j] = list_vals[j - 1];
				list_vals[idx] = val;
				held++;
				r.status = STAT_OK;
			end
			r.held_count = held[4:0];
			awaited_results.push_back(r);
		end else if (act <= ACT_READ_AT) begin
			first = 0;
			while (first < held && list_vals[first] != val)
				first++;
			if (held == 0) begin
				r.status = STAT_EMPTY;
			end else if (act == ACT_READ_AT) begin
				if (pos >= held) begin
					r.status = STAT_NO_POS;
				end else begin
					r.status = STAT_OK;
					r.found_value = list_vals[pos];
				end
			end else if (first >= held) begin
				r.status = STAT_NOT_FOUND;
			end else if (act == ACT_REMOVE_ONE) begin
				for (j = first; j + 1 < held; j++)
					list_vals[j] = list_vals[j + 1];
				held--;
				r.status = STAT_OK;
				r.removed_count = 5'd1;
			end else if (act == ACT_REMOVE_ALL) begin
				n = 0;
				for (j = 0; j < held; j++) begin
					if (list_vals[j] == val)
						n++;
					else
						list_vals[j - n] = list_vals[j];
				end
				held -= n;
				r.status = STAT_OK;
				r.removed_count = n[4:0];
			end else if (act == ACT_FIND_FIRST) begin
				r.status = STAT_OK;
				r.found_position = first[3:0];
			end
			r.held_count = held[4:0];
			if (act == ACT_FIND_ALL && held != 0 && first < held) begin
				n = 0;
				for (j = first; j < held; j++)
					if (list_vals[j] == val)
						n++;
				k = 0;
				for (j = first; j < held; j++) begin
					if (list_vals[j] == val) begin
						r.status = STAT_OK;
						r.found_position = j[3:0];
						r.last = (k == n - 1);
						awaited_results.push_back(r);
						k++;
					end
				end
			end else begin
				awaited_results.push_back(r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t got;
		list_result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			held = 0;
			expected_left = 0;
		end else begin
			if (in_valid && !in_stall)
				apply_to_list(action, value, position);
			if (out_valid && !out_stall) begin
				got = {status, found_value, found_position, held_count, removed_count, last};
				results_seen++;
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result st=%0d val=%0d pos=%0d held=%0d rem=%0d last=%0b",
						$realtime, got.status, got.found_value, got.found_position,
						got.held_count, got.removed_count, got.last);
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: mismatch expected st=%0d val=%0d pos=%0d held=%0d rem=%0d last=%0b",
							$realtime, want.status, want.found_value, want.found_position,
							want.held_count, want.removed_count, want.last);
						$display("%0t:          actual   st=%0d val=%0d pos=%0d held=%0d rem=%0d last=%0b",
							$realtime, got.status, got.found_value, got.found_position,
							got.held_count, got.removed_count, got.last);
					end
				end
			end
			expected_left = awaited_results.size();
		end
	end
endmodule

### verif/tb_sorted_list_table.sv
// Testbench top for the sorted list table: clock, reset, word stimulus, output stalls and verdict.
module tb_sorted_list_table;
	import slt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ActSpareLo = 3'd6;
	localparam logic [2:0] ActSpareHi = 3'd7;
	localparam int CycleLimit = 500000;
	localparam int PhaseWords = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] action = ACT_INSERT;
	logic signed [31:0] value = '0;
	logic [3:0] position = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic signed [31:0] found_value;
	logic [3:0] found_position;
	logic [4:0] held_count;
	logic [4:0] removed_count;
	logic last;

	int fail_count;
	int expected_left;
	int results_seen;
	int words_sent = 0;
	int cycle_count = 0;
	bit sender_calm = 1'b0;
	int stall_left = 0;
	int mode_left = 0;
	bit receiver_calm = 1'b0;

	always #5 clk = ~clk;

	sorted_list_table i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_value(found_value),
		.found_position(found_position),
		.held_count(held_count),
		.removed_count(removed_count),
		.last(last)
	);

	sorted_list_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.value(value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_value(found_value),
		.found_position(found_position),
		.held_count(held_count),
		.removed_count(removed_count),
		.last(last),
		.fail_count(fail_count),
		.expected_left(expected_left),
		.results_seen(results_seen)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_left);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(negedge clk) begin
		int r;
		if (mode_left == 0) begin
			receiver_calm = ($urandom_range(0, 3) == 0);
			mode_left = $urandom_range(20, 80);
		end
		mode_left--;
		if (stall_left == 0 && !receiver_calm) begin
			r = $urandom_range(0, 99);
			if (r < 20)
				stall_left = $urandom_range(1, 3);
			else if (r < 23)
				stall_left = $urandom_range(10, 40);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (sender_calm || r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic signed [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return $signed($urandom_range(0, 7)) - 3;
		if (r == 6)
			return 32'sh8000_0000;
		if (r == 7)
			return 32'sh7fff_ffff;
		return $urandom;
	endfunction

	task automatic send_word(input logic [2:0] act, input logic signed [31:0] val,
			input logic [3:0] pos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		value <= val;
		position <= pos;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_left != 0);
	endtask

	initial begin
		int ins_pct;
		int r;
		logic [2:0] act;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(ACT_REMOVE_ONE, 7, 0);
		send_word(ACT_REMOVE_ALL, 7, 0);
		send_word(ACT_FIND_FIRST, 7, 0);
		send_word(ACT_FIND_ALL, 7, 0);
		send_word(ACT_READ_AT, 0, 0);
		send_word(ActSpareLo, 7, 4'hf);
		send_word(ActSpareHi, -1, 4'ha);
		send_word(ACT_INSERT, 100, 0);
		send_word(ACT_INSERT, -5, 0);
		send_word(ACT_INSERT, 32'sh7fff_ffff, 0);
		send_word(ACT_INSERT, 32'sh8000_0000, 0);
		send_word(ACT_INSERT, 5, 0);
		send_word(ACT_INSERT, 5, 0);
		send_word(ACT_INSERT, 5, 0);
		send_word(ACT_INSERT, 0, 0);
		send_word(ACT_INSERT, -1, 0);
		send_word(ACT_FIND_ALL, 5, 0);
		send_word(ACT_FIND_FIRST, 5, 0);
		send_word(ACT_READ_AT, 0, 0);
		send_word(ACT_READ_AT, 0, 8);
		send_word(ACT_READ_AT, 0, 15);
		send_word(ACT_FIND_FIRST, 42, 0);
		send_word(ACT_REMOVE_ONE, 5, 0);
		send_word(ACT_REMOVE_ALL, 5, 0);
		send_word(ACT_FIND_ALL, 5, 0);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			sender_calm = ($urandom_range(0, 2) == 0);
			r = $urandom_range(0, 2);
			ins_pct = (phase == 0) ? 75 : (r == 0) ? 70 : (r == 1) ? 45 : 20;
			for (int n = 0; n < PhaseWords; n++) begin
				r = $urandom_range(0, 19);
				if ($urandom_range(0, 99) < ins_pct)
					act = ACT_INSERT;
				else if (r == 19)
					act = $urandom_range(0, 1) ? ActSpareHi : ActSpareLo;
				else
					act = ACT_REMOVE_ONE + 3'(r % 5);
				send_word(act, pick_value(), 4'($urandom_range(0, 15)));
			end
			wait_drained();
		end

		repeat (40) @(negedge clk);
		$display("Run covered %0d words over every action, the spare codes, extreme values,",
			words_sent);
		$display("empty and full tables and random stalls; %0d results were checked.",
			results_seen);
		if (fail_count == 0 && expected_left == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
